### sv/mrfc_pkg.sv
// Shared types and constants of the Modbus RTU frame classifier.
`default_nettype none

package mrfc_pkg;

    localparam int unsigned CNT_W = 9;
    localparam logic [CNT_W-1:0] COUNT_MAX = 9'd511;
    localparam int unsigned HDR_DEPTH = 7;

    localparam logic [15:0] CRC_INIT = 16'hFFFF;
    localparam logic [15:0] CRC_POLY = 16'hA001;

    localparam logic [7:0] FN_READ_HOLD  = 8'h03;
    localparam logic [7:0] FN_READ_INPUT = 8'h04;
    localparam logic [7:0] FN_WRITE_ONE  = 8'h06;
    localparam logic [7:0] FN_WRITE_MANY = 8'h10;

    localparam logic [CNT_W-1:0] EXC_LEN             = 9'd5;
    localparam logic [CNT_W-1:0] MIN_DATA_LEN        = 9'd8;
    localparam logic [CNT_W-1:0] WRITE_MANY_OVERHEAD = 9'd9;
    localparam logic [CNT_W-1:0] CRC_BYTES           = 9'd2;

    localparam logic CMD_FRAME_BYTE = 1'b0;
    localparam logic CMD_NOTE_REQ   = 1'b1;

    localparam logic [1:0] TYPE_INVALID   = 2'd0;
    localparam logic [1:0] TYPE_REQUEST   = 2'd1;
    localparam logic [1:0] TYPE_RESPONSE  = 2'd2;
    localparam logic [1:0] TYPE_EXCEPTION = 2'd3;

    typedef struct packed {
        logic        command;
        logic [7:0]  frame_byte;
        logic        last_byte;
        logic [7:0]  sent_address;
        logic [7:0]  sent_function;
        logic [15:0] sent_register;
    } item_t;

    typedef struct packed {
        logic [1:0]  frame_type;
        logic [7:0]  device_address;
        logic [7:0]  function_code;
        logic [15:0] register_address;
        logic [15:0] register_count;
        logic [15:0] write_value;
        logic [7:0]  data_length;
        logic [7:0]  data_offset;
        logic [7:0]  exception_code;
    } result_t;

    typedef struct packed {
        logic [7:0]  address;
        logic [7:0]  func_code;
        logic [15:0] register_addr;
    } tracker_t;

    typedef struct packed {
        logic     load;
        logic     clear;
        tracker_t value;
    } tracker_upd_t;

endpackage

`default_nettype wire

### sv/mrfc_stream_if.sv
// Valid/ready stream interface used for the item and result channels.
`default_nettype none

interface mrfc_stream_if #(
    parameter type payload_t = logic
);
    logic     valid;
    logic     ready;
    payload_t payload;

    modport source (output valid, output payload, input ready);
    modport sink (input valid, input payload, output ready);
endinterface

`default_nettype wire

### sv/modbus_rtu_frame_classifier.sv
// Top level of the Modbus RTU frame classifier.
//
// The item channel carries one received frame byte per transfer (command 0),
// with last_byte set on the final byte, CRC bytes included, or a note of an
// outgoing request (command 1) that only loads the request tracker.
// The result channel carries one classification per frame, produced for the
// transfer that has last_byte set; other transfers produce no result.
// An accepted item is held in an input register; when it advances, the CRC
// fold, header capture and classification run and the result is registered.
// A result passes the input register, then the output register; one item
// is taken per cycle while input ready is high; the byte fold bounds the path.
// Reset presets the CRC to all ones, clears the byte counter and the tracker
// and empties both registers. When the receiver stalls, the result is held in
// the output register; items that produce no result still drain, and input
// ready drops only while a finished frame waits behind the held result.
`default_nettype none

module modbus_rtu_frame_classifier #(
    parameter int unsigned MAX_FRAME_BYTES = 255
) (
    input wire logic clk,
    input wire logic rst_n,
    mrfc_stream_if.sink   item,
    mrfc_stream_if.source result
);

    logic                          in_vld_reg;
    mrfc_pkg::item_t               in_item_reg;
    logic                          out_vld_reg;
    mrfc_pkg::result_t             out_res_reg;
    logic [15:0]                   crc_reg;
    logic [mrfc_pkg::CNT_W-1:0]    cnt_reg;
    logic [6:0][7:0]               hdr_reg;
    mrfc_pkg::tracker_t            trk_reg;

    logic [15:0]                   crc_next;
    logic [mrfc_pkg::CNT_W-1:0]    cnt_next;
    logic [6:0][7:0]               hdr_next;
    mrfc_pkg::tracker_t            trk_next;
    mrfc_pkg::result_t             class_res;
    mrfc_pkg::tracker_upd_t        class_upd;

    logic is_byte;
    logic emits;
    logic advance;
    logic accept;

    assign is_byte = (in_item_reg.command == mrfc_pkg::CMD_FRAME_BYTE);
    assign emits   = is_byte && in_item_reg.last_byte;
    assign advance = in_vld_reg && (!emits || !out_vld_reg || result.ready);
    assign accept  = item.valid && item.ready;

    assign item.ready     = !in_vld_reg || advance;
    assign result.valid   = out_vld_reg;
    assign result.payload = out_res_reg;

    mrfc_crc16 u_crc (
        .crc      (crc_reg),
        .data     (in_item_reg.frame_byte),
        .crc_next (crc_next)
    );

    assign cnt_next = (cnt_reg < mrfc_pkg::COUNT_MAX) ? cnt_reg + 1'b1 : cnt_reg;

    // The current byte is forwarded into the header seen by the classifier.
    always_comb
    begin
        for (int i = 0; i < mrfc_pkg::HDR_DEPTH; i++)
        begin
            hdr_next[i] = (cnt_reg == mrfc_pkg::CNT_W'(i)) ? in_item_reg.frame_byte
                                                           : hdr_reg[i];
        end
    end

    mrfc_classify #(
        .MAX_FRAME_BYTES (MAX_FRAME_BYTES)
    ) u_classify (
        .len     (cnt_next),
        .crc_ok  (crc_next == 16'h0000),
        .hdr     (hdr_next),
        .tracker (trk_reg),
        .result  (class_res),
        .upd     (class_upd)
    );

    always_comb
    begin
        trk_next = trk_reg;
        if (!is_byte)
        begin
            trk_next.address       = in_item_reg.sent_address;
            trk_next.func_code     = in_item_reg.sent_function;
            trk_next.register_addr = in_item_reg.sent_register;
        end
        else if (in_item_reg.last_byte)
        begin
            priority if (class_upd.load)
            begin
                trk_next = class_upd.value;
            end
            else if (class_upd.clear)
            begin
                trk_next = '0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_vld_reg  <= 1'b0;
            out_vld_reg <= 1'b0;
            crc_reg     <= mrfc_pkg::CRC_INIT;
            cnt_reg     <= '0;
            trk_reg     <= '0;
        end
        else
        begin
            if (accept)
            begin
                in_vld_reg <= 1'b1;
            end
            else if (advance)
            begin
                in_vld_reg <= 1'b0;
            end

            if (advance && emits)
            begin
                out_vld_reg <= 1'b1;
            end
            else if (result.ready)
            begin
                out_vld_reg <= 1'b0;
            end

            if (advance)
            begin
                trk_reg <= trk_next;
                if (is_byte)
                begin
                    if (in_item_reg.last_byte)
                    begin
                        crc_reg <= mrfc_pkg::CRC_INIT;
                        cnt_reg <= '0;
                    end
                    else
                    begin
                        crc_reg <= crc_next;
                        cnt_reg <= cnt_next;
                    end
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            in_item_reg <= item.payload;
        end
        if (advance && is_byte)
        begin
            hdr_reg <= hdr_next;
        end
        if (advance && emits)
        begin
            out_res_reg <= class_res;
        end
    end

endmodule

`default_nettype wire

### sv/mrfc_crc16.sv
// Folds one byte into the Modbus CRC-16, one polynomial step per bit.
`default_nettype none

module mrfc_crc16 (
    input  wire logic [15:0] crc,
    input  wire logic [7:0]  data,
    output logic      [15:0] crc_next
);

    always_comb
    begin
        logic [15:0] acc;
        acc = crc ^ {8'h00, data};
        for (int i = 0; i < 8; i++)
        begin
            if (acc[0])
            begin
                acc = (acc >> 1) ^ mrfc_pkg::CRC_POLY;
            end
            else
            begin
                acc = acc >> 1;
            end
        end
        crc_next = acc;
    end

endmodule

`default_nettype wire

### sv/mrfc_classify.sv
// Classifies a completed frame and decides the request tracker update.
`default_nettype none

module mrfc_classify #(
    parameter int unsigned MAX_FRAME_BYTES = 255
) (
    input  wire logic [mrfc_pkg::CNT_W-1:0] len,
    input  wire logic                       crc_ok,
    input  wire logic [6:0][7:0]            hdr,
    input  wire mrfc_pkg::tracker_t         tracker,
    output mrfc_pkg::result_t               result,
    output mrfc_pkg::tracker_upd_t          upd
);

    localparam logic [mrfc_pkg::CNT_W-1:0] MAX_LEN = mrfc_pkg::CNT_W'(MAX_FRAME_BYTES);

    always_comb
    begin
        logic [1:0]  ftype;
        logic [7:0]  addr;
        logic [7:0]  fn;
        logic [15:0] regv;
        logic [15:0] cnt;
        logic [15:0] val;
        logic [7:0]  dlen;
        logic [7:0]  exc;
        logic [mrfc_pkg::CNT_W-1:0] doff;
        logic        single;
        logic        is_read;

        ftype  = mrfc_pkg::TYPE_INVALID;
        addr   = '0;
        fn     = '0;
        regv   = '0;
        cnt    = '0;
        val    = '0;
        dlen   = '0;
        exc    = '0;
        doff   = '0;
        single = 1'b0;
        upd    = '0;
        is_read = (hdr[1] == mrfc_pkg::FN_READ_HOLD) || (hdr[1] == mrfc_pkg::FN_READ_INPUT);

        if (len > MAX_LEN)
        begin
            // Overlong frame: everything stays zero.
        end
        else if (len == mrfc_pkg::EXC_LEN)
        begin
            if (crc_ok)
            begin
                ftype = mrfc_pkg::TYPE_EXCEPTION;
                addr  = hdr[0];
                fn    = hdr[1];
                exc   = hdr[2];
            end
        end
        else if (len >= mrfc_pkg::MIN_DATA_LEN)
        begin
            addr = hdr[0];
            fn   = hdr[1];
            if (crc_ok)
            begin
                if (is_read)
                begin
                    if (len == mrfc_pkg::MIN_DATA_LEN)
                    begin
                        ftype = mrfc_pkg::TYPE_REQUEST;
                        regv  = {hdr[2], hdr[3]};
                        cnt   = {hdr[4], hdr[5]};
                    end
                    else
                    begin
                        dlen = hdr[2];
                        if ({1'b0, dlen} == len - mrfc_pkg::EXC_LEN)
                        begin
                            ftype = mrfc_pkg::TYPE_RESPONSE;
                        end
                    end
                end
                else if (fn == mrfc_pkg::FN_WRITE_ONE)
                begin
                    if (len == mrfc_pkg::MIN_DATA_LEN)
                    begin
                        single = 1'b1;
                        regv   = {hdr[2], hdr[3]};
                        cnt    = 16'd1;
                        val    = {hdr[4], hdr[5]};
                    end
                end
                else if (fn == mrfc_pkg::FN_WRITE_MANY)
                begin
                    regv = {hdr[2], hdr[3]};
                    cnt  = {hdr[4], hdr[5]};
                    if (len == mrfc_pkg::MIN_DATA_LEN)
                    begin
                        ftype = mrfc_pkg::TYPE_RESPONSE;
                    end
                    else
                    begin
                        dlen = hdr[6];
                        if ({1'b0, dlen} == len - mrfc_pkg::WRITE_MANY_OVERHEAD)
                        begin
                            ftype = mrfc_pkg::TYPE_REQUEST;
                        end
                    end
                end

                // A single write echoes the request, so a tracker hit marks the response.
                if (single)
                begin
                    if (addr == tracker.address && fn == tracker.func_code)
                    begin
                        ftype     = mrfc_pkg::TYPE_RESPONSE;
                        upd.clear = 1'b1;
                    end
                    else
                    begin
                        ftype     = mrfc_pkg::TYPE_REQUEST;
                        upd.load  = 1'b1;
                    end
                end
                else if (ftype == mrfc_pkg::TYPE_REQUEST)
                begin
                    upd.load = 1'b1;
                end
                else if (ftype == mrfc_pkg::TYPE_RESPONSE)
                begin
                    if (addr == tracker.address && fn == tracker.func_code && is_read)
                    begin
                        regv = tracker.register_addr;
                    end
                    upd.clear = 1'b1;
                end

                if (ftype != mrfc_pkg::TYPE_INVALID && dlen != 8'd0)
                begin
                    doff = len - {1'b0, dlen} - mrfc_pkg::CRC_BYTES;
                end
            end
        end

        upd.value.address       = addr;
        upd.value.func_code     = fn;
        upd.value.register_addr = regv;

        result.frame_type       = ftype;
        result.device_address   = addr;
        result.function_code    = fn;
        result.register_address = regv;
        result.register_count   = cnt;
        result.write_value      = val;
        result.data_length      = dlen;
        result.data_offset      = doff[7:0];
        result.exception_code   = exc;
    end

endmodule

`default_nettype wire
